// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  // Field widths of the item and result beats
  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned CountW  = 9;

  // Capacity register reset value
  localparam logic [CountW-1:0] CapacityReset = 9'd256;

  typedef enum logic [ActionW-1:0] {
    A_PUSH_BACK  = 3'd0,
    A_PUSH_FRONT = 3'd1,
    A_POP_FRONT  = 3'd2,
    A_PEEK_FRONT = 3'd3,
    A_POP_BACK   = 3'd4,
    A_PEEK_BACK  = 3'd5,
    A_READ_INDEX = 3'd6,
    A_COUNT      = 3'd7
  } deq_action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } deq_status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } deq_state_e;

  typedef struct packed {
    deq_action_e         action;
    logic [ValueW-1:0]   value;
    logic [IndexW-1:0]   index;
  } deq_in_t;

  typedef struct packed {
    logic [ValueW-1:0]   data;
    deq_status_e         status;
    logic [CountW-1:0]   occupancy;
  } deq_out_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// Pushes, count and failed actions register their result directly in the output register;
// pops, peeks and index reads pass first through the registered read of the entry memory.
// Throughput: one item per cycle for pushes and count while results are taken; a read
// takes no new item until its data has reached the output register.
// Reset: head pointer and count clear, capacity returns to 256; the entry memory is not
// cleared, so no clearing pass is needed.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  deq_pkg::deq_in_t            in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output deq_pkg::deq_out_t           out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [deq_pkg::CountW-1:0]  cfg_data_i
);

  localparam int unsigned CW = deq_pkg::CountW;
  localparam int unsigned VW = deq_pkg::ValueW;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned SW = ((PW > deq_pkg::CountW) ? PW : deq_pkg::CountW) + 1;
  localparam int unsigned CapMax = (DEPTH < 511) ? DEPTH : 511;
  localparam logic [deq_pkg::CountW-1:0] CapMaxC = CW'(CapMax);
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);

  // Control and pointer state
  deq_pkg::deq_state_e          state_q, state_d;
  logic [PW-1:0]                head_q, head_d;
  logic [deq_pkg::CountW-1:0]   count_q, count_d;
  logic [deq_pkg::CountW-1:0]   capacity_q;
  logic                         out_valid_q, out_valid_d;
  deq_pkg::deq_out_t            out_q, out_d;

  // Entry memory and its ports
  logic [DATA_WIDTH-1:0]        mem_q [DEPTH];
  logic [DATA_WIDTH-1:0]        rdata_q;
  logic                         mem_we;
  logic [PW-1:0]                mem_waddr;
  logic                         rd_en;
  logic [PW-1:0]                rd_addr;

  logic [deq_pkg::CountW-1:0]   limit;
  logic                         full;
  logic                         empty;
  logic                         in_ready;

  // Ring slot of an offset counted from the head
  function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] head,
                                            input logic [deq_pkg::CountW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[PW-1:0];
  endfunction

  assign limit = (capacity_q > CapMaxC) ? CapMaxC : capacity_q;
  assign full  = (count_q >= limit);
  assign empty = (count_q == '0);

  // Next state, pointer update, memory access and result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    in_ready    = 1'b0;

    unique case (state_q)
      deq_pkg::S_IDLE: begin
        in_ready = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready) begin
          out_valid_d  = 1'b1;
          out_d.data   = '0;
          out_d.status = deq_pkg::ST_OK;
          unique case (in_i.action) inside
            deq_pkg::A_PUSH_BACK: begin
              if (full) begin
                out_d.status = deq_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_at(head_q, count_q);
                count_d   = count_q + 9'd1;
              end
            end
            deq_pkg::A_PUSH_FRONT: begin
              if (full) begin
                out_d.status = deq_pkg::ST_FULL;
              end else begin
                head_d    = (head_q == '0) ? LastSlot : head_q - PW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_d;
                count_d   = count_q + 9'd1;
              end
            end
            deq_pkg::A_POP_FRONT, deq_pkg::A_PEEK_FRONT: begin
              if (empty) begin
                out_d.status = deq_pkg::ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = head_q;
                out_valid_d = 1'b0;
                state_d     = deq_pkg::S_READ;
                if (in_i.action == deq_pkg::A_POP_FRONT) begin
                  head_d  = slot_at(head_q, 9'd1);
                  count_d = count_q - 9'd1;
                end
              end
            end
            deq_pkg::A_POP_BACK, deq_pkg::A_PEEK_BACK: begin
              if (empty) begin
                out_d.status = deq_pkg::ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = slot_at(head_q, count_q - 9'd1);
                out_valid_d = 1'b0;
                state_d     = deq_pkg::S_READ;
                if (in_i.action == deq_pkg::A_POP_BACK) begin
                  count_d = count_q - 9'd1;
                end
              end
            end
            deq_pkg::A_READ_INDEX: begin
              if ({1'b0, in_i.index} >= count_q) begin
                out_d.status = deq_pkg::ST_RANGE;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = slot_at(head_q, {1'b0, in_i.index});
                out_valid_d = 1'b0;
                state_d     = deq_pkg::S_READ;
              end
            end
            default: begin
              out_d.data = VW'(count_q);
            end
          endcase
          out_d.occupancy = count_d;
        end
      end
      deq_pkg::S_READ: begin
        // Output register is free here: the read was only issued when it was
        out_valid_d     = 1'b1;
        out_d.data      = VW'(rdata_q);
        out_d.status    = deq_pkg::ST_OK;
        out_d.occupancy = count_q;
        state_d         = deq_pkg::S_IDLE;
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      capacity_q  <= deq_pkg::CapacityReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_i.value[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/deq_checker.sv =====
module deq_sva_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  deq_pkg::deq_in_t            in_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  deq_pkg::deq_out_t           out_o
);

  // Hold a result beat until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat dropped or changed while stalled");

  // Stall the input side while a result beat is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while result register is blocked");

  // Report zero data on any failure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != deq_pkg::ST_OK |-> out_o.data == '0)
    else $error("nonzero data on failed action");

  // Report empty only with nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == deq_pkg::ST_EMPTY |-> out_o.occupancy == '0)
    else $error("empty status with entries held");

  // Answer a count item in the next cycle with the occupancy as data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.action == deq_pkg::A_COUNT
    |=> out_valid_o && out_o.data[8:0] == out_o.occupancy && out_o.data[63:9] == '0)
    else $error("count result wrong or late");

endmodule

bind double_ended_queue_unit deq_sva_checker u_deq_checker (.*);
